// ===== rtl/mvna_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mvna_pkg: shared types and constants
// Field widths, function codes, command and status groups for the vertex
// normal accumulator.
// ----------------------------------------------------------------------------
package mvna_pkg;

	localparam int MAX_VERTICES = 1024;
	localparam int ADDR_W       = $clog2(MAX_VERTICES);
	localparam int IDX_W        = 10;
	localparam int POS_W        = 24;
	localparam int ACC_W        = 60;
	localparam int DIF_W        = POS_W + 1;
	localparam int NRM_W        = 2 * DIF_W + 1;
	localparam int SQ_IN_W      = 31;
	localparam int MUL_W        = SQ_IN_W + 2;
	localparam int PROD_W       = 64;
	localparam int LEN_W        = 33;
	localparam int REM_W        = LEN_W + 1;
	localparam int OUT_W        = 16;
	localparam int FRAC_W       = 16;
	localparam int SQRT_STEPS   = 32;
	localparam int STEP_W       = 6;
	localparam int CROSS_STEPS  = 6;
	localparam int SQ_STEPS     = 3;

	typedef enum logic [1:0] {
		FN_LOAD  = 2'd0,
		FN_FACE  = 2'd1,
		FN_QUERY = 2'd2,
		FN_NOP   = 2'd3
	} func_t;

	// Order matters: face steps issue codes 0..5 from the step counter.
	typedef enum logic [3:0] {
		MO_UYVZ = 4'd0,
		MO_UZVY = 4'd1,
		MO_UZVX = 4'd2,
		MO_UXVZ = 4'd3,
		MO_UXVY = 4'd4,
		MO_UYVX = 4'd5,
		MO_SQX  = 4'd6,
		MO_SQY  = 4'd7,
		MO_SQZ  = 4'd8
	} mul_op_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_F_RD,
		ST_F_CAP,
		ST_F_MUL,
		ST_F_ARD,
		ST_F_AWR,
		ST_Q_RD,
		ST_Q_MAG,
		ST_Q_SHIFT,
		ST_Q_SQ,
		ST_Q_SQRT,
		ST_Q_DIV,
		ST_Q_OUT
	} st_t;

	typedef struct packed {
		logic              clr_wr;
		logic [ADDR_W-1:0] clr_addr;
		logic              load_wr;
		logic              take;
		logic              pos_rd;
		logic [1:0]        corner;
		logic              acc_wr;
		logic              mul_go;
		mul_op_t           mul_op;
		logic              mag_load;
		logic              shift;
		logic              sqrt_init;
		logic              sqrt_step;
		logic              div_init;
		logic              div_step;
		logic              div_store;
		logic              out_load;
	} mvna_cmd_t;

	typedef struct packed {
		logic bad_a;
		logic bad_any;
		logic deg;
		logic big;
	} mvna_sts_t;

endpackage

// ===== rtl/mvna_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mvna_in_if: item channel into the accumulator
// Valid/ready channel carrying function code, corner indices and position.
// ----------------------------------------------------------------------------
interface mvna_in_if import mvna_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic [1:0]              func;
	logic [IDX_W-1:0]        index_a;
	logic [IDX_W-1:0]        index_b;
	logic [IDX_W-1:0]        index_c;
	logic signed [POS_W-1:0] pos_x;
	logic signed [POS_W-1:0] pos_y;
	logic signed [POS_W-1:0] pos_z;

	modport source (output valid, func, index_a, index_b, index_c, pos_x, pos_y, pos_z,
		input ready);
	modport sink (input valid, func, index_a, index_b, index_c, pos_x, pos_y, pos_z,
		output ready);
endinterface

// ===== rtl/mvna_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mvna_out_if: result channel out of the accumulator
// Valid/ready channel carrying the unit normal and the degenerate flag.
// ----------------------------------------------------------------------------
interface mvna_out_if import mvna_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic signed [OUT_W-1:0] norm_x;
	logic signed [OUT_W-1:0] norm_y;
	logic signed [OUT_W-1:0] norm_z;
	logic                    degenerate;

	modport source (output valid, norm_x, norm_y, norm_z, degenerate, input ready);
	modport sink (input valid, norm_x, norm_y, norm_z, degenerate, output ready);
endinterface

// ===== rtl/mvna_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mvna_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module mvna_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

// ===== rtl/mvna_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mvna_dp: datapath of the vertex normal accumulator
// Position and accumulator memories, shared multiplier, shift, square root
// and divider registers, result register.
// ----------------------------------------------------------------------------
module mvna_dp import mvna_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  mvna_cmd_t               cmd,
	output mvna_sts_t               sts,
	input  logic [IDX_W-1:0]        index_a,
	input  logic [IDX_W-1:0]        index_b,
	input  logic [IDX_W-1:0]        index_c,
	input  logic signed [POS_W-1:0] pos_x,
	input  logic signed [POS_W-1:0] pos_y,
	input  logic signed [POS_W-1:0] pos_z,
	output logic signed [OUT_W-1:0] norm_x,
	output logic signed [OUT_W-1:0] norm_y,
	output logic signed [OUT_W-1:0] norm_z,
	output logic                    degenerate
);
	function automatic logic idx_bad(input logic [IDX_W-1:0] i);
		idx_bad = (32'(i) >= 32'(MAX_VERTICES));
	endfunction

	function automatic logic signed [ACC_W-1:0] sat_add(input logic signed [ACC_W-1:0] a,
			input logic signed [NRM_W-1:0] n);
		logic signed [ACC_W:0] s;
		s = (ACC_W+1)'(a) + (ACC_W+1)'(n);
		if (s[ACC_W] != s[ACC_W-1]) begin
			sat_add = s[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
		end else begin
			sat_add = s[ACC_W-1:0];
		end
	endfunction

	logic [ADDR_W-1:0]      idx_q [3];
	logic                   bad_q;
	logic [ADDR_W-1:0]      sel_addr;
	logic [3*POS_W-1:0]     pos_rd_w;
	logic [3*POS_W-1:0]     pos_q [3];
	logic                   pos_rd_s1;
	logic [1:0]             corner_s1;
	logic [3*ACC_W-1:0]     acc_rd_w;
	logic [3*ACC_W-1:0]     acc_wd;
	logic                   acc_we;
	logic [ADDR_W-1:0]      acc_waddr;
	logic signed [DIF_W-1:0] ux, uy, uz, vx, vy, vz;
	logic signed [MUL_W-1:0] ma, mb;
	logic signed [2*MUL_W-1:0] prod_full;
	logic signed [PROD_W-1:0] prod_s1;
	mul_op_t                mop_s1;
	logic                   mgo_s1;
	logic signed [NRM_W-1:0] n_q [3];
	logic [ACC_W-1:0]       m_q [3];
	logic [2:0]             neg_q;
	logic                   deg_q;
	logic [PROD_W-1:0]      sq_q;
	logic [PROD_W-1:0]      root_q;
	logic [PROD_W-1:0]      bit_q;
	logic [PROD_W-1:0]      trial;
	logic [LEN_W-1:0]       len_w;
	logic [REM_W-1:0]       rem_q;
	logic [REM_W:0]         rem_sh;
	logic [REM_W:0]         dvs;
	logic [FRAC_W-1:0]      nlo_q;
	logic [FRAC_W-1:0]      quo_q;
	logic [OUT_W-1:0]       qclamp;
	logic signed [OUT_W-1:0] res_q [3];
	logic [ACC_W-1:0]       m_sel;

	always_comb begin
		case (cmd.corner)
			2'd0:    sel_addr = idx_q[0];
			2'd1:    sel_addr = idx_q[1];
			default: sel_addr = idx_q[2];
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			idx_q[0] <= ADDR_W'(index_a);
			idx_q[1] <= ADDR_W'(index_b);
			idx_q[2] <= ADDR_W'(index_c);
			bad_q    <= idx_bad(index_a);
		end
	end

	assign sts.bad_a   = idx_bad(index_a);
	assign sts.bad_any = idx_bad(index_a) | idx_bad(index_b) | idx_bad(index_c);

	// Position store: {z, y, x}
	mvna_ram #(.WIDTH(3*POS_W), .DEPTH(MAX_VERTICES)) u_pos_ram (
		.clk   (clk),
		.we    (cmd.load_wr),
		.waddr (ADDR_W'(index_a)),
		.wdata ({pos_z, pos_y, pos_x}),
		.raddr (sel_addr),
		.rdata (pos_rd_w)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_rd_s1 <= 1'b0;
			mgo_s1    <= 1'b0;
		end else begin
			pos_rd_s1 <= cmd.pos_rd;
			mgo_s1    <= cmd.mul_go;
		end
	end

	always_ff @(posedge clk) begin
		corner_s1 <= cmd.corner;
		if (pos_rd_s1) begin
			case (corner_s1)
				2'd0:    pos_q[0] <= pos_rd_w;
				2'd1:    pos_q[1] <= pos_rd_w;
				default: pos_q[2] <= pos_rd_w;
			endcase
		end
	end

	// Edge vectors u = p1 - p0, v = p2 - p1
	always_comb begin
		ux = DIF_W'($signed(pos_q[1][0*POS_W +: POS_W])) - DIF_W'($signed(pos_q[0][0*POS_W +: POS_W]));
		uy = DIF_W'($signed(pos_q[1][1*POS_W +: POS_W])) - DIF_W'($signed(pos_q[0][1*POS_W +: POS_W]));
		uz = DIF_W'($signed(pos_q[1][2*POS_W +: POS_W])) - DIF_W'($signed(pos_q[0][2*POS_W +: POS_W]));
		vx = DIF_W'($signed(pos_q[2][0*POS_W +: POS_W])) - DIF_W'($signed(pos_q[1][0*POS_W +: POS_W]));
		vy = DIF_W'($signed(pos_q[2][1*POS_W +: POS_W])) - DIF_W'($signed(pos_q[1][1*POS_W +: POS_W]));
		vz = DIF_W'($signed(pos_q[2][2*POS_W +: POS_W])) - DIF_W'($signed(pos_q[1][2*POS_W +: POS_W]));
	end

	// Shared multiplier operand select
	always_comb begin
		case (cmd.mul_op)
			MO_UYVZ: begin ma = MUL_W'(uy); mb = MUL_W'(vz); end
			MO_UZVY: begin ma = MUL_W'(uz); mb = MUL_W'(vy); end
			MO_UZVX: begin ma = MUL_W'(uz); mb = MUL_W'(vx); end
			MO_UXVZ: begin ma = MUL_W'(ux); mb = MUL_W'(vz); end
			MO_UXVY: begin ma = MUL_W'(ux); mb = MUL_W'(vy); end
			MO_UYVX: begin ma = MUL_W'(uy); mb = MUL_W'(vx); end
			MO_SQX: begin
				ma = $signed({2'b00, m_q[0][SQ_IN_W-1:0]});
				mb = ma;
			end
			MO_SQY: begin
				ma = $signed({2'b00, m_q[1][SQ_IN_W-1:0]});
				mb = ma;
			end
			MO_SQZ: begin
				ma = $signed({2'b00, m_q[2][SQ_IN_W-1:0]});
				mb = ma;
			end
			default: begin ma = '0; mb = '0; end
		endcase
	end

	assign prod_full = ma * mb;

	always_ff @(posedge clk) begin
		if (cmd.mul_go) begin
			prod_s1 <= prod_full[PROD_W-1:0];
			mop_s1  <= cmd.mul_op;
		end
	end

	// Accumulator store: {z, y, x}
	always_comb begin
		acc_we    = cmd.clr_wr | cmd.load_wr | cmd.acc_wr;
		acc_waddr = cmd.clr_wr ? cmd.clr_addr : (cmd.load_wr ? ADDR_W'(index_a) : sel_addr);
		acc_wd    = '0;
		if (cmd.acc_wr) begin
			acc_wd = {sat_add($signed(acc_rd_w[2*ACC_W +: ACC_W]), n_q[2]),
				sat_add($signed(acc_rd_w[1*ACC_W +: ACC_W]), n_q[1]),
				sat_add($signed(acc_rd_w[0*ACC_W +: ACC_W]), n_q[0])};
		end
	end

	mvna_ram #(.WIDTH(3*ACC_W), .DEPTH(MAX_VERTICES)) u_acc_ram (
		.clk   (clk),
		.we    (acc_we),
		.waddr (acc_waddr),
		.wdata (acc_wd),
		.raddr (sel_addr),
		.rdata (acc_rd_w)
	);

	// Square root trial and divider terms
	assign trial  = root_q + bit_q;
	assign len_w  = (root_q == '0) ? LEN_W'(1) : root_q[LEN_W-1:0];
	assign rem_sh = {rem_q, nlo_q[FRAC_W-1]};
	assign dvs    = (REM_W+1)'({len_w, 1'b0});
	assign qclamp = (quo_q > {1'b0, {(OUT_W-1){1'b1}}}) ? {1'b0, {(OUT_W-1){1'b1}}} : quo_q;

	always_comb begin
		case (cmd.corner)
			2'd0:    m_sel = m_q[0];
			2'd1:    m_sel = m_q[1];
			default: m_sel = m_q[2];
		endcase
	end

	always_ff @(posedge clk) begin
		if (mgo_s1) begin
			case (mop_s1)
				MO_UYVZ: n_q[0] <= NRM_W'(prod_s1);
				MO_UZVY: n_q[0] <= n_q[0] - NRM_W'(prod_s1);
				MO_UZVX: n_q[1] <= NRM_W'(prod_s1);
				MO_UXVZ: n_q[1] <= n_q[1] - NRM_W'(prod_s1);
				MO_UXVY: n_q[2] <= NRM_W'(prod_s1);
				MO_UYVX: n_q[2] <= n_q[2] - NRM_W'(prod_s1);
				MO_SQX:  sq_q <= prod_s1;
				default: sq_q <= sq_q + prod_s1;
			endcase
		end else if (cmd.sqrt_step) begin
			if (sq_q >= trial) begin
				sq_q   <= sq_q - trial;
				root_q <= (root_q >> 1) + bit_q;
			end else begin
				root_q <= root_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
		if (cmd.sqrt_init) begin
			root_q <= '0;
			bit_q  <= {2'b01, {(PROD_W-2){1'b0}}};
		end

		if (cmd.mag_load) begin
			for (int k = 0; k < 3; k++) begin
				neg_q[k] <= acc_rd_w[k*ACC_W + ACC_W - 1];
				m_q[k]   <= acc_rd_w[k*ACC_W + ACC_W - 1] ? (ACC_W'(0) - acc_rd_w[k*ACC_W +: ACC_W])
					: acc_rd_w[k*ACC_W +: ACC_W];
				res_q[k] <= '0;
			end
			deg_q <= bad_q | (acc_rd_w == '0);
		end else if (cmd.shift) begin
			for (int k = 0; k < 3; k++) begin
				m_q[k] <= m_q[k] >> 1;
			end
		end

		if (cmd.div_init) begin
			rem_q <= REM_W'(m_sel[SQ_IN_W-1:0]) + REM_W'(len_w[LEN_W-1:FRAC_W]);
			nlo_q <= len_w[FRAC_W-1:0];
			quo_q <= '0;
		end else if (cmd.div_step) begin
			if (rem_sh >= dvs) begin
				rem_q <= REM_W'(rem_sh - dvs);
				quo_q <= {quo_q[FRAC_W-2:0], 1'b1};
			end else begin
				rem_q <= REM_W'(rem_sh);
				quo_q <= {quo_q[FRAC_W-2:0], 1'b0};
			end
			nlo_q <= nlo_q << 1;
		end

		if (cmd.div_store) begin
			case (cmd.corner)
				2'd0:    res_q[0] <= neg_q[0] ? $signed(OUT_W'(0) - qclamp) : $signed(qclamp);
				2'd1:    res_q[1] <= neg_q[1] ? $signed(OUT_W'(0) - qclamp) : $signed(qclamp);
				default: res_q[2] <= neg_q[2] ? $signed(OUT_W'(0) - qclamp) : $signed(qclamp);
			endcase
		end

		if (cmd.out_load) begin
			norm_x     <= res_q[0];
			norm_y     <= res_q[1];
			norm_z     <= res_q[2];
			degenerate <= deg_q;
		end
	end

	assign sts.deg = deg_q;
	assign sts.big = (|m_q[0][ACC_W-1:SQ_IN_W]) | (|m_q[1][ACC_W-1:SQ_IN_W])
		| (|m_q[2][ACC_W-1:SQ_IN_W]);
endmodule

// ===== rtl/mvna_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mvna_ctrl: controller of the vertex normal accumulator
// Sequences the clearing pass, face accumulation and normal query.
// ----------------------------------------------------------------------------
module mvna_ctrl import mvna_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic [1:0] in_func,
	output logic       in_ready,
	output logic       out_valid,
	input  logic       out_ready,
	input  mvna_sts_t  sts,
	output mvna_cmd_t  cmd
);
	st_t               state_q, state_d;
	logic [STEP_W-1:0] step_q, step_d;
	logic [1:0]        corner_q, corner_d;
	logic [ADDR_W-1:0] clr_q, clr_d;
	logic              out_valid_q;
	logic              out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			step_q      <= '0;
			corner_q    <= '0;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			step_q   <= step_d;
			corner_q <= corner_d;
			clr_q    <= clr_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d      = state_q;
		step_d       = step_q;
		corner_d     = corner_q;
		clr_d        = clr_q;
		in_ready     = 1'b0;
		cmd          = '0;
		cmd.corner   = corner_q;
		cmd.clr_addr = clr_q;
		cmd.mul_op   = MO_UYVZ;
		case (state_q)
			ST_CLEAR: begin
				cmd.clr_wr = 1'b1;
				clr_d      = clr_q + 1'b1;
				if (clr_q == ADDR_W'(MAX_VERTICES - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				corner_d = '0;
				step_d   = '0;
				if (in_valid) begin
					case (func_t'(in_func))
						FN_LOAD: cmd.load_wr = !sts.bad_a;
						FN_FACE: begin
							cmd.take = 1'b1;
							if (!sts.bad_any) begin
								state_d = ST_F_RD;
							end
						end
						FN_QUERY: begin
							cmd.take = 1'b1;
							state_d  = ST_Q_RD;
						end
						default: ;
					endcase
				end
			end
			ST_F_RD: begin
				cmd.pos_rd = 1'b1;
				corner_d   = corner_q + 1'b1;
				if (corner_q == 2'd2) begin
					corner_d = '0;
					state_d  = ST_F_CAP;
				end
			end
			ST_F_CAP: begin
				state_d = ST_F_MUL;
			end
			ST_F_MUL: begin
				// Issue one cross term a cycle; each product passes through prod_s1 before it is folded into n_q.
				if (step_q < STEP_W'(CROSS_STEPS)) begin
					cmd.mul_go = 1'b1;
					cmd.mul_op = mul_op_t'(step_q[3:0]);
					step_d     = step_q + 1'b1;
				end else begin
					step_d  = '0;
					state_d = ST_F_ARD;
				end
			end
			ST_F_ARD: begin
				state_d = ST_F_AWR;
			end
			ST_F_AWR: begin
				cmd.acc_wr = 1'b1;
				if (corner_q == 2'd2) begin
					state_d = ST_IDLE;
				end else begin
					corner_d = corner_q + 1'b1;
					state_d  = ST_F_ARD;
				end
			end
			ST_Q_RD: begin
				state_d = ST_Q_MAG;
			end
			ST_Q_MAG: begin
				cmd.mag_load = 1'b1;
				state_d      = ST_Q_SHIFT;
			end
			ST_Q_SHIFT: begin
				if (sts.deg) begin
					state_d = ST_Q_OUT;
				end else if (sts.big) begin
					cmd.shift = 1'b1;
				end else begin
					step_d  = '0;
					state_d = ST_Q_SQ;
				end
			end
			ST_Q_SQ: begin
				cmd.sqrt_init = (step_q == '0);
				cmd.mul_go    = (step_q < STEP_W'(SQ_STEPS));
				case (step_q[1:0])
					2'd0:    cmd.mul_op = MO_SQX;
					2'd1:    cmd.mul_op = MO_SQY;
					default: cmd.mul_op = MO_SQZ;
				endcase
				step_d = step_q + 1'b1;
				if (step_q == STEP_W'(SQ_STEPS)) begin
					step_d  = '0;
					state_d = ST_Q_SQRT;
				end
			end
			ST_Q_SQRT: begin
				cmd.sqrt_step = 1'b1;
				step_d        = step_q + 1'b1;
				if (step_q == STEP_W'(SQRT_STEPS - 1)) begin
					step_d   = '0;
					corner_d = '0;
					state_d  = ST_Q_DIV;
				end
			end
			ST_Q_DIV: begin
				step_d = step_q + 1'b1;
				if (step_q == '0) begin
					cmd.div_init = 1'b1;
				end else if (step_q <= STEP_W'(FRAC_W)) begin
					cmd.div_step = 1'b1;
				end else begin
					cmd.div_store = 1'b1;
					step_d        = '0;
					if (corner_q == 2'd2) begin
						state_d = ST_Q_OUT;
					end else begin
						corner_d = corner_q + 1'b1;
					end
				end
			end
			ST_Q_OUT: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end
endmodule

// ===== rtl/mesh_vertex_normal_accumulator.sv =====
`timescale 1ns / 1ps
// Throughput: one item at a time; query time is set by the 32-step square root,
// the 3 x 18-step divider and the one-bit-a-cycle normalizing shift.
// Reset: asynchronous, active low; then a pass over all 1024 entries clears the accumulators.
// ----------------------------------------------------------------------------
// mesh_vertex_normal_accumulator: area-weighted vertex normal engine
// Stores vertex positions, accumulates face cross products per corner with
// saturation and returns unit normals in signed Q1.15.
// ----------------------------------------------------------------------------
module mesh_vertex_normal_accumulator import mvna_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	mvna_in_if.sink  in_ch,
	mvna_out_if.source out_ch
);
	mvna_cmd_t cmd;
	mvna_sts_t sts;
	logic      in_ready;
	logic      out_valid;

	// Controller: owns the handshakes, the step counters and the clear sweep.
	mvna_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_func   (in_ch.func),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ch.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// Datapath: memories, shared multiplier, root and divider, result register.
	mvna_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.index_a    (in_ch.index_a),
		.index_b    (in_ch.index_b),
		.index_c    (in_ch.index_c),
		.pos_x      (in_ch.pos_x),
		.pos_y      (in_ch.pos_y),
		.pos_z      (in_ch.pos_z),
		.norm_x     (out_ch.norm_x),
		.norm_y     (out_ch.norm_y),
		.norm_z     (out_ch.norm_z),
		.degenerate (out_ch.degenerate)
	);

	// The result register decouples the sides: a new item may transfer in
	// while a result still waits downstream.
	assign in_ch.ready  = in_ready;
	assign out_ch.valid = out_valid;

`ifndef SYNTHESIS
	// Never overwrite a result that has not transferred out.
	a_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_ch.valid || out_ch.ready))
		else $error("result register overwritten");

	// Hold input off during the clear sweep.
	a_clr_block: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clr_wr |-> !in_ch.ready)
		else $error("input ready during clear sweep");

	// At most one accumulator write source per cycle.
	a_acc_wr: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.acc_wr, cmd.load_wr, cmd.clr_wr}))
		else $error("accumulator write conflict");

	// A result appears only after a load of the result register.
	a_out_rise: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_ch.valid) |-> $past(cmd.out_load))
		else $error("result valid without load");
`endif
endmodule
